[design/scl_pkg.sv]
// Shared types, token codes and character constants for the shell command lexer.
// Depends on nothing; the lexer top level imports it.
package scl_pkg;

   // Token codes carried on the result channel.
   typedef enum logic [3:0] {
      KIND_WORD_CHAR  = 4'd0,
      KIND_WORD_END   = 4'd1,
      KIND_PIPE       = 4'd2,
      KIND_IN         = 4'd3,
      KIND_OUT        = 4'd4,
      KIND_APPEND     = 4'd5,
      KIND_HEREDOC    = 4'd6,
      KIND_AND        = 4'd7,
      KIND_OR         = 4'd8,
      KIND_SEMI       = 4'd9,
      KIND_LPAREN     = 4'd10,
      KIND_RPAREN     = 4'd11,
      KIND_EOL        = 4'd12,
      KIND_LONE_AMP   = 4'd13,
      KIND_EMPTY_WORD = 4'd14
   } kind_type;

   // Operator held back while the next character decides single or double form.
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_PIPE = 3'd1,
      OP_IN   = 3'd2,
      OP_OUT  = 3'd3,
      OP_AMP  = 3'd4
   } op_type;

   // Quote tracking, one-hot.
   typedef enum logic [2:0] {
      Q_OUT    = 3'b001,
      Q_SINGLE = 3'b010,
      Q_DOUBLE = 3'b100
   } quote_type;

   // Character constants.
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_PIPE   = 8'h7C;
   localparam logic [7:0] CHR_LT     = 8'h3C;
   localparam logic [7:0] CHR_GT     = 8'h3E;
   localparam logic [7:0] CHR_AMP    = 8'h26;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   // Result slots produced by one item, and the result queue behind them.
   localparam int SLOTS       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int SLOT_W      = $clog2(SLOTS + 1);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   // One queued result.
   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] chr;
      logic       last;
   } result_type;

   // Effect of one character inside a word.
   typedef struct packed {
      logic      emit;
      quote_type quote;
      logic      has;
   } word_step_type;

   // Effect of one character outside a word with no operator held.
   typedef struct packed {
      logic      emit;
      kind_type  kind;
      logic [7:0] chr;
      op_type    pend;
      logic      opens_word;
      quote_type quote;
      logic      has;
   } idle_step_type;

   function automatic logic is_space(logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_CR);
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return (c == CHR_SEMI) || (c == CHR_LPAREN) || (c == CHR_RPAREN);
   endfunction

   function automatic op_type op_code(logic [7:0] c);
      op_type op;
      op = OP_NONE;
      if (c == CHR_PIPE) op = OP_PIPE;
      if (c == CHR_LT)   op = OP_IN;
      if (c == CHR_GT)   op = OP_OUT;
      if (c == CHR_AMP)  op = OP_AMP;
      return op;
   endfunction

   function automatic logic [7:0] op_char(op_type op);
      logic [7:0] c;
      unique case (op)
         OP_PIPE: c = CHR_PIPE;
         OP_IN:   c = CHR_LT;
         OP_OUT:  c = CHR_GT;
         OP_AMP:  c = CHR_AMP;
         default: c = CHR_NUL;
      endcase
      return c;
   endfunction

   function automatic kind_type op_single(op_type op);
      kind_type k;
      unique case (op)
         OP_PIPE: k = KIND_PIPE;
         OP_IN:   k = KIND_IN;
         OP_OUT:  k = KIND_OUT;
         OP_AMP:  k = KIND_LONE_AMP;
         default: k = KIND_WORD_CHAR;
      endcase
      return k;
   endfunction

   function automatic kind_type op_double(op_type op);
      kind_type k;
      unique case (op)
         OP_PIPE: k = KIND_OR;
         OP_IN:   k = KIND_HEREDOC;
         OP_OUT:  k = KIND_APPEND;
         OP_AMP:  k = KIND_AND;
         default: k = KIND_WORD_CHAR;
      endcase
      return k;
   endfunction

   // A character inside a word: an unquoted quote opens, the matching quote closes, both are dropped, the rest is kept.
   function automatic word_step_type word_char(logic [7:0] c, quote_type q, logic has);
      word_step_type w;
      w.emit  = 1'b0;
      w.quote = q;
      w.has   = has;
      unique case (q)
         Q_SINGLE: begin
            if (c == CHR_SQUOTE) w.quote = Q_OUT;
            else w.emit = 1'b1;
         end
         Q_DOUBLE: begin
            if (c == CHR_DQUOTE) w.quote = Q_OUT;
            else w.emit = 1'b1;
         end
         default: begin
            if (c == CHR_SQUOTE) w.quote = Q_SINGLE;
            else if (c == CHR_DQUOTE) w.quote = Q_DOUBLE;
            else w.emit = 1'b1;
         end
      endcase
      if (w.emit) w.has = 1'b1;
      return w;
   endfunction

   // A character between words: skip blanks, hold operators, emit punctuation,
   // or start a new word.
   function automatic idle_step_type idle_char(logic [7:0] c);
      idle_step_type s;
      word_step_type w;
      op_type        op;
      s.emit       = 1'b0;
      s.kind       = KIND_WORD_CHAR;
      s.chr        = CHR_NUL;
      s.pend       = OP_NONE;
      s.opens_word = 1'b0;
      s.quote      = Q_OUT;
      s.has        = 1'b0;
      op = op_code(c);
      priority if (is_space(c)) begin
         s.emit = 1'b0;
      end else if (op != OP_NONE) begin
         s.pend = op;
      end else if (c == CHR_SEMI) begin
         s.emit = 1'b1;
         s.kind = KIND_SEMI;
      end else if (c == CHR_LPAREN) begin
         s.emit = 1'b1;
         s.kind = KIND_LPAREN;
      end else if (c == CHR_RPAREN) begin
         s.emit = 1'b1;
         s.kind = KIND_RPAREN;
      end else begin
         w = word_char(c, Q_OUT, 1'b0);
         s.opens_word = 1'b1;
         s.emit       = w.emit;
         s.quote      = w.quote;
         s.has        = w.has;
         s.chr        = c;
      end
      return s;
   endfunction

endpackage

[design/shell_command_lexer.sv]
// Shell command lexer top level: input register, token logic and result queue.
// Depends on scl_pkg for token codes, character constants and step functions.
//
// Usage:
//   The request channel (req_valid, req_stall, req_char_byte, req_end_of_line)
//   carries one command-line character or an end-of-line mark per transfer.
//   A zero byte acts as end of line. The response channel (rsp_valid,
//   rsp_stall, rsp_token_kind, rsp_char_value, rsp_last_of_run) carries the
//   tokens; rsp_last_of_run marks the final token caused by one request.
//   Whitespace between words causes no token at all.
//   The tokens of a request pass through the input register and then the result queue.
//   Throughput: one request per cycle while tokens drain at one per cycle.
//   A request is moved from the input register into the token logic only
//   when the four-entry result queue has room for three tokens, so requests
//   that make two tokens, or a stalled receiver, hold off req for a while.
//   When the receiver stalls, the queued tokens hold and the input stalls as
//   the queue fills. Reset empties the queue and input register and returns
//   the lexer to no operator held, outside any word and outside quotes.
module shell_command_lexer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_line,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_char_value,
   output logic       rsp_last_of_run
);
   import scl_pkg::*;

   // Input register.
   logic       item_valid_ff, item_valid_in;
   logic [7:0] item_char_ff;
   logic       item_eol_ff;

   // Lexer state.
   op_type    pend_ff, pend_in;
   logic      inw_ff, inw_in;
   quote_type quote_ff, quote_in;
   logic      has_ff, has_in;

   // Result queue; entry zero is the head.
   result_type           queue_ff [QUEUE_DEPTH];
   result_type           queue_in [QUEUE_DEPTH];
   logic [COUNT_W-1:0]   count_ff, count_in;

   // Token logic signals.
   logic                 eol_w;
   op_type               p_w;
   word_step_type        wstep;
   idle_step_type        istep;
   logic [SLOT_W-1:0]    n_w;
   kind_type             slot_kind [SLOTS];
   logic [7:0]           slot_chr  [SLOTS];

   logic                 advance;
   logic                 accept;
   logic                 pop;
   logic [COUNT_W-1:0]   remaining;
   logic [COUNT_W-1:0]   push_n;

   // Handshakes: an item advances only when the queue can take every token it may make.
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign advance   = item_valid_ff && (count_ff <= COUNT_W'(QUEUE_DEPTH - SLOTS));
   assign req_stall = item_valid_ff && !advance;
   assign rsp_valid = (count_ff != '0);

   assign rsp_token_kind  = queue_ff[0].kind;
   assign rsp_char_value  = queue_ff[0].chr;
   assign rsp_last_of_run = queue_ff[0].last;

   // Token logic for the item in the input register.
   always_comb begin
      pend_in  = pend_ff;
      inw_in   = inw_ff;
      quote_in = quote_ff;
      has_in   = has_ff;
      n_w      = '0;
      wstep    = word_char(item_char_ff, quote_ff, has_ff);
      istep    = idle_char(item_char_ff);
      for (int i = 0; i < SLOTS; i++) begin
         slot_kind[i] = KIND_WORD_CHAR;
         slot_chr[i]  = CHR_NUL;
      end
      eol_w = item_eol_ff || (item_char_ff == CHR_NUL);
      p_w   = pend_ff;
      if (!(p_w == OP_PIPE || p_w == OP_IN || p_w == OP_OUT || p_w == OP_AMP)) begin
         p_w     = OP_NONE;
         pend_in = OP_NONE;
      end

      priority if (eol_w) begin
         // End of line flushes a held operator and an open word, then ends the line.
         if (p_w != OP_NONE) begin
            slot_kind[n_w] = op_single(p_w);
            n_w = n_w + SLOT_W'(1);
         end
         if (inw_ff) begin
            slot_kind[n_w] = has_ff ? KIND_WORD_END : KIND_EMPTY_WORD;
            n_w = n_w + SLOT_W'(1);
         end
         slot_kind[n_w] = KIND_EOL;
         n_w      = n_w + SLOT_W'(1);
         pend_in  = OP_NONE;
         inw_in   = 1'b0;
         quote_in = Q_OUT;
         has_in   = 1'b0;
      end else if (p_w != OP_NONE) begin
         // A held operator is resolved by this character.
         pend_in = OP_NONE;
         if (item_char_ff == op_char(p_w)) begin
            slot_kind[n_w] = op_double(p_w);
            n_w = n_w + SLOT_W'(1);
         end else begin
            slot_kind[n_w] = op_single(p_w);
            n_w = n_w + SLOT_W'(1);
            if (inw_ff) begin
               if (wstep.emit) begin
                  slot_chr[n_w] = item_char_ff;
                  n_w = n_w + SLOT_W'(1);
               end
               quote_in = wstep.quote;
               has_in   = wstep.has;
            end else begin
               if (istep.emit) begin
                  slot_kind[n_w] = istep.kind;
                  slot_chr[n_w]  = istep.chr;
                  n_w = n_w + SLOT_W'(1);
               end
               pend_in  = istep.pend;
               inw_in   = istep.opens_word;
               quote_in = istep.quote;
               has_in   = istep.has;
            end
         end
      end else if (inw_ff) begin
         if (quote_ff == Q_OUT && (is_space(item_char_ff) ||
             op_code(item_char_ff) != OP_NONE || is_punct(item_char_ff))) begin
            // An unquoted delimiter closes the word.
            if (has_ff) begin
               slot_kind[n_w] = KIND_WORD_END;
               n_w = n_w + SLOT_W'(1);
               if (istep.emit) begin
                  slot_kind[n_w] = istep.kind;
                  slot_chr[n_w]  = istep.chr;
                  n_w = n_w + SLOT_W'(1);
               end
               pend_in  = istep.pend;
               inw_in   = istep.opens_word;
               quote_in = istep.quote;
               has_in   = istep.has;
            end else begin
               // An empty word swallows its delimiter.
               slot_kind[n_w] = KIND_EMPTY_WORD;
               n_w      = n_w + SLOT_W'(1);
               inw_in   = 1'b0;
               quote_in = Q_OUT;
               has_in   = 1'b0;
            end
         end else begin
            if (wstep.emit) begin
               slot_chr[n_w] = item_char_ff;
               n_w = n_w + SLOT_W'(1);
            end
            quote_in = wstep.quote;
            has_in   = wstep.has;
         end
      end else begin
         if (istep.emit) begin
            slot_kind[n_w] = istep.kind;
            slot_chr[n_w]  = istep.chr;
            n_w = n_w + SLOT_W'(1);
         end
         pend_in  = istep.pend;
         inw_in   = istep.opens_word;
         quote_in = istep.quote;
         has_in   = istep.has;
      end
   end

   // Result queue: shift out the head on a transfer, append new tokens behind the rest.
   always_comb begin
      remaining = count_ff - COUNT_W'(pop);
      push_n    = advance ? COUNT_W'(n_w) : '0;
      count_in  = remaining + push_n;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         logic [COUNT_W-1:0] j;
         j = COUNT_W'(i) - remaining;
         queue_in[i] = queue_ff[i];
         if (COUNT_W'(i) < remaining) begin
            if (i < QUEUE_DEPTH - 1 && pop) queue_in[i] = queue_ff[(i + 1) % QUEUE_DEPTH];
         end else if (j < push_n) begin
            queue_in[i].kind = slot_kind[j[SLOT_W-1:0]];
            queue_in[i].chr  = slot_chr[j[SLOT_W-1:0]];
            queue_in[i].last = (j == push_n - COUNT_W'(1));
         end
      end
   end

   // Input register control.
   always_comb begin
      item_valid_in = item_valid_ff;
      if (advance) item_valid_in = 1'b0;
      if (accept)  item_valid_in = 1'b1;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         count_ff      <= '0;
         pend_ff       <= OP_NONE;
         inw_ff        <= 1'b0;
         quote_ff      <= Q_OUT;
         has_ff        <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         count_ff      <= count_in;
         if (advance) begin
            pend_ff  <= pend_in;
            inw_ff   <= inw_in;
            quote_ff <= quote_in;
            has_ff   <= has_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_char_ff <= req_char_byte;
         item_eol_ff  <= req_end_of_line;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

`ifndef SYNTHESIS
   // The queue never holds more tokens than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   // An operator is only ever held between words.
   assert property (@(posedge clock) disable iff (reset)
      (pend_ff != OP_NONE) |-> !inw_ff)
      else $error("operator held inside a word");

   // Open quotes and collected characters belong to a word.
   assert property (@(posedge clock) disable iff (reset)
      ((quote_ff != Q_OUT) || has_ff) |-> inw_ff)
      else $error("word state set outside a word");

   // A stalled head token stays in place.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(queue_ff[0])))
      else $error("stalled result changed");
`endif

endmodule

[verif/shell_command_lexer_check.sv]
// Checker for the shell command lexer: watches the request and response channels,
// predicts the token stream of every request transfer and compares the responses.
// Depends on scl_pkg for token codes, operator codes and character constants.
`timescale 1ns / 100ps

module shell_command_lexer_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_end_of_line,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [3:0] rsp_token_kind,
   input  logic [7:0] rsp_char_value,
   input  logic       rsp_last_of_run,
   output int         error_count,
   output int         tokens_waiting
);

   import scl_pkg::*;

   // Quote state of the word being lexed.
   typedef enum logic [1:0] {
      QUOTE_NONE   = 2'd0,
      QUOTE_SINGLE = 2'd1,
      QUOTE_DOUBLE = 2'd2
   } quote_mode_type;

   // One token the lexer is expected to send.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] chr;
      logic       last;
   } token_type;

   token_type   expected_tokens [$];
   int          mismatch_total = 0;
   int          backlog = 0;

   // Lexer state as the predictor sees it.
   op_type         pending_op = OP_NONE;
   logic           in_word = 1'b0;
   quote_mode_type quote_state = QUOTE_NONE;
   logic           word_has_chars = 1'b0;

   // Tokens caused by the transfer being predicted.
   kind_type    step_kinds [4];
   logic [7:0]  step_chars [4];
   int          step_count;

   assign error_count    = mismatch_total;
   assign tokens_waiting = backlog;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_total++;
   endtask

   function automatic logic is_blank(logic [7:0] c);
      return (c == CHR_SPACE) || (c == CHR_TAB) || (c == CHR_LF) || (c == CHR_CR);
   endfunction

   function automatic op_type operator_of(logic [7:0] c);
      op_type op;
      case (c)
         CHR_PIPE: op = OP_PIPE;
         CHR_LT:   op = OP_IN;
         CHR_GT:   op = OP_OUT;
         CHR_AMP:  op = OP_AMP;
         default:  op = OP_NONE;
      endcase
      return op;
   endfunction

   // Unquoted characters that close a word.
   function automatic logic ends_word(logic [7:0] c);
      return is_blank(c) || (operator_of(c) != OP_NONE) || (c == CHR_SEMI) ||
             (c == CHR_LPAREN) || (c == CHR_RPAREN);
   endfunction

   function automatic logic [7:0] op_symbol(op_type op);
      logic [7:0] c;
      case (op)
         OP_PIPE: c = CHR_PIPE;
         OP_IN:   c = CHR_LT;
         OP_OUT:  c = CHR_GT;
         OP_AMP:  c = CHR_AMP;
         default: c = CHR_NUL;
      endcase
      return c;
   endfunction

   function automatic kind_type single_kind(op_type op);
      kind_type k;
      case (op)
         OP_PIPE: k = KIND_PIPE;
         OP_IN:   k = KIND_IN;
         OP_OUT:  k = KIND_OUT;
         default: k = KIND_LONE_AMP;
      endcase
      return k;
   endfunction

   function automatic kind_type double_kind(op_type op);
      kind_type k;
      case (op)
         OP_PIPE: k = KIND_OR;
         OP_IN:   k = KIND_HEREDOC;
         OP_OUT:  k = KIND_APPEND;
         default: k = KIND_AND;
      endcase
      return k;
   endfunction

   task automatic add_token(input kind_type kind, input logic [7:0] chr);
      if (step_count < 4) begin
         step_kinds[step_count] = kind;
         step_chars[step_count] = chr;
         step_count++;
      end
   endtask

   task automatic close_word();
      in_word        = 1'b0;
      quote_state    = QUOTE_NONE;
      word_has_chars = 1'b0;
   endtask

   // A character inside a word: the matching quote closes, an unquoted quote
   // opens, everything else becomes part of the word.
   task automatic take_word_char(input logic [7:0] c);
      logic keep;
      case (quote_state)
         QUOTE_SINGLE: keep = (c != CHR_SQUOTE);
         QUOTE_DOUBLE: keep = (c != CHR_DQUOTE);
         default:      keep = (c != CHR_SQUOTE) && (c != CHR_DQUOTE);
      endcase
      if (keep) begin
         add_token(KIND_WORD_CHAR, c);
         word_has_chars = 1'b1;
      end else if (quote_state != QUOTE_NONE) begin
         quote_state = QUOTE_NONE;
      end else if (c == CHR_SQUOTE) begin
         quote_state = QUOTE_SINGLE;
      end else begin
         quote_state = QUOTE_DOUBLE;
      end
   endtask

   // A character between words with no operator held.
   task automatic take_idle_char(input logic [7:0] c);
      op_type op;
      op = operator_of(c);
      if (!is_blank(c)) begin
         if (op != OP_NONE) begin
            pending_op = op;
         end else if (c == CHR_SEMI) begin
            add_token(KIND_SEMI, CHR_NUL);
         end else if (c == CHR_LPAREN) begin
            add_token(KIND_LPAREN, CHR_NUL);
         end else if (c == CHR_RPAREN) begin
            add_token(KIND_RPAREN, CHR_NUL);
         end else begin
            in_word = 1'b1;
            take_word_char(c);
         end
      end
   endtask

   // Predicts the tokens of one request transfer and queues them.
   task automatic lex_transfer(input logic [7:0] c, input logic eol_flag);
      logic      line_end;
      op_type    held;
      token_type entry;
      step_count = 0;
      line_end   = eol_flag || (c == CHR_NUL);
      held       = pending_op;
      if (line_end) begin
         // Flush the held operator and the open word, then end the line.
         if (held != OP_NONE) add_token(single_kind(held), CHR_NUL);
         if (in_word) begin
            if (word_has_chars) add_token(KIND_WORD_END, CHR_NUL);
            else add_token(KIND_EMPTY_WORD, CHR_NUL);
         end
         add_token(KIND_EOL, CHR_NUL);
         pending_op = OP_NONE;
         close_word();
      end else if (held != OP_NONE) begin
         // The held operator doubles up or goes out alone.
         pending_op = OP_NONE;
         if (c == op_symbol(held)) begin
            add_token(double_kind(held), CHR_NUL);
         end else begin
            add_token(single_kind(held), CHR_NUL);
            if (in_word) take_word_char(c);
            else take_idle_char(c);
         end
      end else if (in_word) begin
         if (quote_state == QUOTE_NONE && ends_word(c)) begin
            // An empty word swallows its terminator.
            if (word_has_chars) begin
               add_token(KIND_WORD_END, CHR_NUL);
               close_word();
               take_idle_char(c);
            end else begin
               add_token(KIND_EMPTY_WORD, CHR_NUL);
               close_word();
            end
         end else begin
            take_word_char(c);
         end
      end else begin
         take_idle_char(c);
      end
      for (int i = 0; i < step_count; i++) begin
         entry.kind = step_kinds[i];
         entry.chr  = step_chars[i];
         entry.last = (i == step_count - 1);
         expected_tokens.push_back(entry);
      end
   endtask

   // Compares one response transfer with the oldest expected token.
   task automatic check_token();
      token_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch($sformatf("token kind %0d char %02h arrived with nothing expected",
                                   rsp_token_kind, rsp_char_value));
      end else begin
         want = expected_tokens.pop_front();
         if (rsp_token_kind !== want.kind)
            report_mismatch($sformatf("token kind %0d, expected %0d",
                                      rsp_token_kind, want.kind));
         if (rsp_char_value !== want.chr)
            report_mismatch($sformatf("char value %02h, expected %02h",
                                      rsp_char_value, want.chr));
         if (rsp_last_of_run !== want.last)
            report_mismatch($sformatf("last of run %0b, expected %0b",
                                      rsp_last_of_run, want.last));
      end
   endtask

   // Responses are checked before the request of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         expected_tokens.delete();
         pending_op = OP_NONE;
         close_word();
      end else begin
         if (rsp_valid && !rsp_stall) check_token();
         if (req_valid && !req_stall) lex_transfer(req_char_byte, req_end_of_line);
      end
      backlog = expected_tokens.size();
   end

endmodule

[verif/shell_command_lexer_test.sv]
// Testbench top for the shell command lexer: drives directed and random command
// lines in bursts, stalls the token side, and gives the verdict from the checker.
// Depends on scl_pkg, shell_command_lexer and shell_command_lexer_check.
`timescale 1ns / 100ps

module shell_command_lexer_test;

   import scl_pkg::*;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      STALL_NONE  = 2'd0,
      STALL_LIGHT = 2'd1,
      STALL_HEAVY = 2'd2,
      STALL_HOLD  = 2'd3
   } stall_mode_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_byte = 8'h00;
   logic       req_end_of_line = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [3:0] rsp_token_kind;
   logic [7:0] rsp_char_value;
   logic       rsp_last_of_run;
   int         error_count;
   int         tokens_waiting;

   int             sent_count = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   shell_command_lexer i_dut (.*);

   shell_command_lexer_check i_check (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Sends one item, holding it until the transfer, then idles if the burst is over.
   task automatic send_char(input logic [7:0] c, input logic eol);
      req_valid       <= 1'b1;
      req_char_byte   <= c;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(50, 120);
         else burst_left = $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // Ends a line either by the end marker or by a zero byte.
   task automatic send_line_end();
      if ($urandom_range(0, 9) < 7) send_char(8'($urandom_range(0, 255)), 1'b1);
      else send_char(CHR_NUL, 1'b0);
   endtask

   function automatic logic [7:0] blank_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0:       c = CHR_SPACE;
         1:       c = CHR_TAB;
         2:       c = CHR_LF;
         default: c = CHR_CR;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] operator_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0:       c = CHR_PIPE;
         1:       c = CHR_LT;
         2:       c = CHR_GT;
         default: c = CHR_AMP;
      endcase
      return c;
   endfunction

   // Word characters: lower-case letters, digits and high bytes are never special.
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      case ($urandom_range(0, 3))
         0, 1:    c = 8'($urandom_range(8'h61, 8'h7A));
         2:       c = 8'($urandom_range(8'h30, 8'h39));
         default: c = 8'($urandom_range(8'h80, 8'hFF));
      endcase
      return c;
   endfunction

   // The token side stalls in runs of a randomly chosen pattern.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         if (stall_mode == STALL_HOLD) stall_left = $urandom_range(1, 8);
         else stall_left = $urandom_range(1, 40);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 2) == 0);
         STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
         default:     rsp_stall <= 1'b1;
      endcase
   end

   initial begin
      int         pieces;
      int         count;
      logic [7:0] q;
      logic [7:0] c;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed lines: every operator in single and double form, a lone
      // ampersand flushed by end of line, punctuation, empty words ended by a
      // blank and by punctuation, an unclosed quote ended by a zero byte, and
      // the extreme character values.
      send_text("a|b||&&&");
      send_char(CHR_NUL, 1'b1);
      send_text("<<>>><;()");
      send_char(8'hFF, 1'b1);
      send_text("'' \"a b");
      send_char(CHR_NUL, 1'b0);
      send_text("'';");
      send_char(8'hFF, 1'b0);
      send_char(8'h5A, 1'b1);

      // Random lines: mostly well-formed pieces, some raw byte noise.
      while (sent_count < 380) begin
         if ($urandom_range(0, 99) < 15) begin
            count = $urandom_range(1, 12);
            repeat (count) send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         end else begin
            pieces = $urandom_range(1, 8);
            repeat (pieces) begin
               q = ($urandom_range(0, 1) == 0) ? CHR_SQUOTE : CHR_DQUOTE;
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: begin
                     count = $urandom_range(1, 5);
                     repeat (count) send_char(plain_char(), 1'b0);
                  end
                  4: begin
                     // Quoted text with arbitrary content, sometimes left open.
                     send_char(q, 1'b0);
                     count = $urandom_range(0, 5);
                     repeat (count) send_char(8'($urandom_range(1, 255)), 1'b0);
                     if ($urandom_range(0, 99) < 85) send_char(q, 1'b0);
                  end
                  5: begin
                     send_char(q, 1'b0);
                     send_char(q, 1'b0);
                  end
                  6, 7: begin
                     c = operator_char();
                     send_char(c, 1'b0);
                     if ($urandom_range(0, 1) == 0) send_char(c, 1'b0);
                     else if ($urandom_range(0, 4) == 0) send_char(operator_char(), 1'b0);
                  end
                  8: begin
                     case ($urandom_range(0, 2))
                        0:       send_char(CHR_SEMI, 1'b0);
                        1:       send_char(CHR_LPAREN, 1'b0);
                        default: send_char(CHR_RPAREN, 1'b0);
                     endcase
                  end
                  default: begin
                     count = $urandom_range(1, 3);
                     repeat (count) send_char(blank_char(), 1'b0);
                  end
               endcase
               if ($urandom_range(0, 9) < 6) send_char(blank_char(), 1'b0);
            end
         end
         send_line_end();
      end
      req_valid <= 1'b0;

      // Drain the tokens, then give late extras time to show up.
      while (tokens_waiting != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0 && tokens_waiting == 0) begin
         $display("shell_command_lexer test passed");
      end else begin
         $display("shell_command_lexer test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("shell_command_lexer test failed");
      $finish;
   end

endmodule
